// ===== sv/assert_macros.svh =====
// Assertion macros shared by the frame parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define TDFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Check that a condition is followed by an outcome on the next edge
`define TDFP_ASSERT_NEXT(lbl, clk, rst_n, cond, outcome) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (outcome)) \
        else $error("%m: assertion failed");

`endif

// ===== sv/tdfp_pkg.sv =====
// Types, constants and helper functions of the date/time frame parser
`timescale 1ns / 1ps

package tdfp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DATE_FIELDS = 6;
    localparam int DIGIT_SLOTS = 2 * DATE_FIELDS;
    localparam int SLOT_W      = $clog2(DIGIT_SLOTS);

    localparam logic [7:0] START_BYTE     = 8'hFF;
    localparam logic [4:0] TAG_FIRST_MASK = 5'h1F;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;
    localparam logic [7:0] ASCII_NINE     = 8'h39;
    localparam logic [7:0] NUL_BYTE       = 8'h00;

    localparam logic CFG_TAG_VALUE  = 1'b0;
    localparam logic CFG_TAG_LENGTH = 1'b1;

    typedef struct packed {
        logic              finish;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
        logic              ok;
        logic [6:0]        length;
    } cmd_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
    endfunction

    function automatic logic [6:0] pair_value(input logic [7:0] a, input logic [7:0] b);
        logic [6:0] tens;
        logic [6:0] units;
        tens  = 7'(a[3:0]);
        units = 7'(b[3:0]);
        if (!is_digit(a))
        begin
            return 7'd0;
        end
        if (!is_digit(b))
        begin
            return tens;
        end
        return 7'(tens * 7'd10) + units;
    endfunction

endpackage

// ===== sv/tlv_datetime_frame_parser.sv =====
// Top level of the TLV date/time frame parser
// Takes one byte every cycle while the four-entry command queue has room.
// A result passes the command queue, behind older commands, then the result register.
// A held result stops the queue at the next checksum command; a full queue drops in_ready.
// Reset clears the frame state, the tag registers (length one) and the date fields.
`timescale 1ns / 1ps

module tlv_datetime_frame_parser
#(
    parameter int TAG_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        checksum_ok,
    output logic [6:0]  day,
    output logic [6:0]  month,
    output logic [6:0]  year,
    output logic [6:0]  hour,
    output logic [6:0]  minute,
    output logic [6:0]  second
);

    tdfp_pkg::cmd_t push_cmd;
    tdfp_pkg::cmd_t head;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    assign cfg_ready = 1'b1;

    tdfp_front #(
        .TAG_BYTES (TAG_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    tdfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    tdfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .checksum_ok (checksum_ok),
        .day         (day),
        .month       (month),
        .year        (year),
        .hour        (hour),
        .minute      (minute),
        .second      (second)
    );

endmodule

// ===== sv/tdfp_queue.sv =====
// Short command queue between the frame front end and the field back end
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdfp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tdfp_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output tdfp_pkg::cmd_t  head,
    output logic            empty,
    output logic            full
);

    tdfp_pkg::cmd_t                     slot_reg [tdfp_pkg::QUEUE_DEPTH];
    logic [tdfp_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [tdfp_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [tdfp_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [tdfp_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [tdfp_pkg::QCNT_W-1:0]        count_reg;
    logic [tdfp_pkg::QCNT_W-1:0]        count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == tdfp_pkg::QCNT_W'(tdfp_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + tdfp_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + tdfp_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tdfp_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tdfp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `TDFP_ASSERT(a_no_push_when_full, clk, rst_n, !(push && full))
    `TDFP_ASSERT(a_no_pop_when_empty, clk, rst_n, !(pop && empty))
    `TDFP_ASSERT(a_count_bound, clk, rst_n, count_reg <= tdfp_pkg::QCNT_W'(tdfp_pkg::QUEUE_DEPTH))

endmodule

// ===== sv/tdfp_front.sv =====
// Front end: byte intake, frame state, tag check, checksum and digit routing
`timescale 1ns / 1ps

module tdfp_front
#(
    parameter int TAG_BYTES = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic            cfg_index,
    input  logic [31:0]     cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      rx_byte,
    input  logic            queue_full,
    output logic            push,
    output tdfp_pkg::cmd_t  push_cmd
);

    localparam int TPOS_W = $clog2(TAG_BYTES + 1);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_TAG1 = 3'd1;
    localparam logic [2:0] PH_TAGN = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CSUM = 3'd5;

    logic [31:0]       tag_value_reg;
    logic [2:0]        tag_length_reg;

    logic [2:0]        phase_reg;
    logic [2:0]        phase_next;
    logic [7:0]        xor_reg;
    logic [7:0]        xor_next;
    logic [6:0]        length_reg;
    logic [6:0]        length_next;
    logic [6:0]        pos_reg;
    logic [6:0]        pos_next;
    logic [2:0]        field_reg;
    logic [2:0]        field_next;
    logic [1:0]        sub_reg;
    logic [1:0]        sub_next;
    logic [TPOS_W-1:0] tag_pos_reg;
    logic [TPOS_W-1:0] tag_pos_next;
    logic [7:0]        tag_reg  [TAG_BYTES];
    logic [7:0]        tag_next [TAG_BYTES];

    logic [7:0]        got_byte  [8];
    logic [7:0]        want_byte [8];
    logic              tag_match;
    logic              accept;
    logic              tag_room;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign tag_room = (tag_pos_reg < TPOS_W'(TAG_BYTES));

    for (genvar k = 0; k < 8; k++)
    begin : g_pad
        if (k < TAG_BYTES)
        begin : g_got
            assign got_byte[k] = tag_reg[k];
        end
        else
        begin : g_got_zero
            assign got_byte[k] = 8'h00;
        end
        if (k < 4)
        begin : g_want
            assign want_byte[k] = tag_value_reg[31 - 8 * k -: 8];
        end
        else
        begin : g_want_zero
            assign want_byte[k] = 8'h00;
        end
    end

    always_comb
    begin
        tag_match = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            if ((4'(k) < {1'b0, tag_length_reg}) && (want_byte[k] != got_byte[k]))
            begin
                tag_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        xor_next     = xor_reg;
        length_next  = length_reg;
        pos_next     = pos_reg;
        field_next   = field_reg;
        sub_next     = sub_reg;
        tag_pos_next = tag_pos_reg;
        tag_next     = tag_reg;
        push         = 1'b0;
        push_cmd     = '0;
        push_cmd.slot   = {field_reg, sub_reg[0]};
        push_cmd.data   = rx_byte;
        push_cmd.length = length_reg;
        push_cmd.ok     = (xor_reg == rx_byte) && tag_match;

        if (accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == tdfp_pkg::START_BYTE)
                    begin
                        xor_next     = tdfp_pkg::START_BYTE;
                        length_next  = '0;
                        pos_next     = '0;
                        field_next   = '0;
                        sub_next     = '0;
                        tag_pos_next = '0;
                        for (int k = 0; k < TAG_BYTES; k++)
                        begin
                            tag_next[k] = 8'h00;
                        end
                        phase_next   = PH_TAG1;
                    end
                end
                PH_TAG1, PH_TAGN:
                begin
                    if ((phase_reg == PH_TAGN)
                        || (rx_byte[4:0] == tdfp_pkg::TAG_FIRST_MASK))
                    begin
                        xor_next = xor_reg ^ rx_byte;
                        for (int k = 0; k < TAG_BYTES; k++)
                        begin
                            if (tag_pos_reg == TPOS_W'(k))
                            begin
                                tag_next[k] = rx_byte;
                            end
                        end
                        if ((phase_reg == PH_TAG1) || rx_byte[7])
                        begin
                            if (tag_room)
                            begin
                                tag_pos_next = tag_pos_reg + TPOS_W'(1);
                            end
                            phase_next = PH_TAGN;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_LEN:
                begin
                    if (!rx_byte[7])
                    begin
                        xor_next    = xor_reg ^ rx_byte;
                        length_next = rx_byte[6:0];
                        phase_next  = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_DATA:
                begin
                    if (!tag_match)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ rx_byte;
                        if ((field_reg < 3'(tdfp_pkg::DATE_FIELDS)) && (sub_reg != 2'd2))
                        begin
                            push = 1'b1;
                        end
                        if ((8'(pos_reg) + 8'd1) >= 8'(length_reg))
                        begin
                            phase_next = PH_CSUM;
                        end
                        if (pos_reg != 7'h7F)
                        begin
                            pos_next = pos_reg + 7'd1;
                        end
                        if (field_reg < 3'(tdfp_pkg::DATE_FIELDS))
                        begin
                            if (sub_reg == 2'd2)
                            begin
                                sub_next   = 2'd0;
                                field_next = field_reg + 3'd1;
                            end
                            else
                            begin
                                sub_next = sub_reg + 2'd1;
                            end
                        end
                    end
                end
                PH_CSUM:
                begin
                    push            = 1'b1;
                    push_cmd.finish = 1'b1;
                    phase_next      = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_value_reg  <= 32'h0;
            tag_length_reg <= 3'd1;
            phase_reg      <= PH_IDLE;
            xor_reg        <= 8'h00;
            length_reg     <= '0;
            pos_reg        <= '0;
            field_reg      <= '0;
            sub_reg        <= '0;
            tag_pos_reg    <= '0;
            for (int k = 0; k < TAG_BYTES; k++)
            begin
                tag_reg[k] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    tdfp_pkg::CFG_TAG_VALUE:  tag_value_reg  <= cfg_data;
                    tdfp_pkg::CFG_TAG_LENGTH: tag_length_reg <= cfg_data[2:0];
                    default:                  tag_value_reg  <= tag_value_reg;
                endcase
            end
            phase_reg   <= phase_next;
            xor_reg     <= xor_next;
            length_reg  <= length_next;
            pos_reg     <= pos_next;
            field_reg   <= field_next;
            sub_reg     <= sub_next;
            tag_pos_reg <= tag_pos_next;
            tag_reg     <= tag_next;
        end
    end

endmodule

// ===== sv/tdfp_back.sv =====
// Back end: digit store, field conversion and the result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdfp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            queue_empty,
    input  tdfp_pkg::cmd_t  head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            checksum_ok,
    output logic [6:0]      day,
    output logic [6:0]      month,
    output logic [6:0]      year,
    output logic [6:0]      hour,
    output logic [6:0]      minute,
    output logic [6:0]      second
);

    logic [7:0] digit_reg [tdfp_pkg::DIGIT_SLOTS];
    logic [6:0] date_reg  [tdfp_pkg::DATE_FIELDS];
    logic [6:0] date_next [tdfp_pkg::DATE_FIELDS];
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       ok_reg;
    logic       finish_pop;
    logic [7:0] second_char;

    assign pop        = !queue_empty && (!head.finish || !out_valid_reg || out_ready);
    assign finish_pop = pop && head.finish;

    always_comb
    begin
        date_next   = date_reg;
        second_char = tdfp_pkg::NUL_BYTE;
        for (int f = 0; f < tdfp_pkg::DATE_FIELDS; f++)
        begin
            second_char = (head.length > 7'(3 * f + 1)) ? digit_reg[2 * f + 1]
                                                        : tdfp_pkg::NUL_BYTE;
            if (head.ok && (head.length > 7'(3 * f)))
            begin
                date_next[f] = tdfp_pkg::pair_value(digit_reg[2 * f], second_char);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            for (int f = 0; f < tdfp_pkg::DATE_FIELDS; f++)
            begin
                date_reg[f] <= 7'd0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (finish_pop)
            begin
                ok_reg   <= head.ok;
                date_reg <= date_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !head.finish)
        begin
            digit_reg[head.slot] <= head.data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign checksum_ok = ok_reg;
    assign day         = date_reg[0];
    assign month       = date_reg[1];
    assign year        = date_reg[2];
    assign hour        = date_reg[3];
    assign minute      = date_reg[4];
    assign second      = date_reg[5];

    `TDFP_ASSERT(a_finish_needs_free_output, clk, rst_n,
        !finish_pop || !out_valid_reg || out_ready)
    `TDFP_ASSERT_NEXT(a_finish_shows_result, clk, rst_n, finish_pop, out_valid_reg)
    `TDFP_ASSERT(a_slot_in_range, clk, rst_n,
        !(pop && !head.finish) || (head.slot < 4'(tdfp_pkg::DIGIT_SLOTS)))

endmodule

// ===== verif/tlv_datetime_frame_parser_test.sv =====
// Self-checking testbench of the TLV date/time frame parser: directed frames, then random traffic
`timescale 1ns / 1ps

module tlv_datetime_frame_parser_test;

    localparam int TAG_BYTES      = 4;
    localparam int RANDOM_ITEMS   = 1020;
    localparam int PHASES         = 6;
    localparam int SETTLE         = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TEXT_BYTES     = 17;

    typedef enum logic [2:0] {
        AWAIT_START,
        GOT_START,
        IN_TAG,
        AWAIT_LENGTH,
        IN_DATA,
        AWAIT_SUM
    } parse_t;

    typedef enum logic [1:0] {
        ALWAYS_READY,
        HALF_READY,
        SELDOM_READY,
        MOSTLY_READY
    } stall_mode_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_SUM,
        ROW_BAD_SUM
    } row_kind_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] day;
        logic [6:0] month;
        logic [6:0] year;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
    } stamp_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] value;
        logic       typed;
        stamp_t     want;
    } vector_t;

    localparam stamp_t NO_STAMP   = '0;
    localparam stamp_t STAMP_GOOD = '{1'b1, 7'd99, 7'd7, 7'd0, 7'd0, 7'd0, 7'd0};
    localparam stamp_t STAMP_BAD  = '{1'b0, 7'd99, 7'd7, 7'd0, 7'd0, 7'd0, 7'd0};

    localparam vector_t DIRECTED [29] = '{
        '{ROW_BYTE,    8'h00, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'hFF, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h3F, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h01, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h05, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h39, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h39, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h2E, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h30, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h37, 1'b0, NO_STAMP},
        '{ROW_SUM,     8'h00, 1'b1, STAMP_GOOD},
        '{ROW_BYTE,    8'hFF, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h3F, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h01, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h01, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h41, 1'b0, NO_STAMP},
        '{ROW_BAD_SUM, 8'h00, 1'b1, STAMP_BAD},
        '{ROW_BYTE,    8'hFF, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h3F, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h01, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h00, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h00, 1'b0, NO_STAMP},
        '{ROW_SUM,     8'h00, 1'b1, STAMP_GOOD},
        '{ROW_BYTE,    8'hFF, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h3F, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h01, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h80, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'hFF, 1'b0, NO_STAMP},
        '{ROW_BYTE,    8'h20, 1'b0, NO_STAMP}
    };

    localparam logic [2:0] PHASE_LENGTH [PHASES] = '{3'd4, 3'd7, 3'd0, 3'd2, 3'd3, 3'd1};

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        checksum_ok;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [6:0]  year;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;

    logic [31:0] tag_value_cfg;
    logic [2:0]  tag_length_cfg;
    parse_t      parse_st;
    logic [7:0]  xor_acc;
    logic [6:0]  frame_len;
    logic [6:0]  data_pos;
    logic [2:0]  tag_pos;
    logic [7:0]  tag_seen [TAG_BYTES];
    logic [7:0]  text_bytes [tdfp_pkg::DIGIT_SLOTS];
    logic [6:0]  date_now [tdfp_pkg::DATE_FIELDS];

    stamp_t      pending_dates [$];
    int          items_sent;
    int          results_seen;
    int          mismatches;
    int          stuck_cycles;
    int          burst_left;
    bit          gaps_on;

    tlv_datetime_frame_parser #(
        .TAG_BYTES (TAG_BYTES)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .checksum_ok (checksum_ok),
        .day         (day),
        .month       (month),
        .year        (year),
        .hour        (hour),
        .minute      (minute),
        .second      (second)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic tag_ok();
        logic [7:0] want;
        logic [7:0] got;
        for (int k = 0; k < int'(tag_length_cfg); k++)
        begin
            want = (k < 4) ? tag_value_cfg[31 - 8 * k -: 8] : 8'h00;
            got  = (k < TAG_BYTES) ? tag_seen[k] : 8'h00;
            if (want != got)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic [6:0] digits_value(input logic [7:0] hi, input logic [7:0] lo);
        logic hi_num;
        logic lo_num;
        hi_num = (hi >= tdfp_pkg::ASCII_ZERO) && (hi <= tdfp_pkg::ASCII_NINE);
        lo_num = (lo >= tdfp_pkg::ASCII_ZERO) && (lo <= tdfp_pkg::ASCII_NINE);
        if (!hi_num)
        begin
            return 7'd0;
        end
        if (!lo_num)
        begin
            return 7'(int'(hi) - int'(tdfp_pkg::ASCII_ZERO));
        end
        return 7'((int'(hi) - int'(tdfp_pkg::ASCII_ZERO)) * 10
                  + int'(lo) - int'(tdfp_pkg::ASCII_ZERO));
    endfunction

    function automatic logic [31:0] make_tag(input int n);
        logic [31:0] v;
        logic [7:0]  b;
        v = '0;
        for (int k = 0; k < n; k++)
        begin
            b = 8'($urandom);
            if (k == 0)
            begin
                b[4:0] = tdfp_pkg::TAG_FIRST_MASK;
            end
            if (k < n - 1)
            begin
                b[7] = 1'b1;
            end
            v[31 - 8 * k -: 8] = b;
        end
        return v;
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        stamp_t res;
        int     pos;
        case (parse_st)
            AWAIT_START:
            begin
                if (b == tdfp_pkg::START_BYTE)
                begin
                    xor_acc   = tdfp_pkg::START_BYTE;
                    frame_len = '0;
                    data_pos  = '0;
                    tag_pos   = '0;
                    foreach (tag_seen[k]) tag_seen[k] = '0;
                    foreach (text_bytes[k]) text_bytes[k] = '0;
                    parse_st  = GOT_START;
                end
            end
            GOT_START:
            begin
                if (b[4:0] == tdfp_pkg::TAG_FIRST_MASK)
                begin
                    xor_acc ^= b;
                    if (tag_pos < TAG_BYTES)
                    begin
                        tag_seen[tag_pos] = b;
                        tag_pos++;
                    end
                    parse_st = IN_TAG;
                end
                else
                begin
                    parse_st = AWAIT_START;
                end
            end
            IN_TAG:
            begin
                xor_acc ^= b;
                if (tag_pos < TAG_BYTES)
                begin
                    tag_seen[tag_pos] = b;
                end
                if (b[7])
                begin
                    if (tag_pos < TAG_BYTES)
                    begin
                        tag_pos++;
                    end
                end
                else
                begin
                    parse_st = AWAIT_LENGTH;
                end
            end
            AWAIT_LENGTH:
            begin
                if (!b[7])
                begin
                    xor_acc ^= b;
                    frame_len = b[6:0];
                    parse_st  = IN_DATA;
                end
                else
                begin
                    parse_st = AWAIT_START;
                end
            end
            IN_DATA:
            begin
                if (!tag_ok())
                begin
                    parse_st = AWAIT_START;
                end
                else
                begin
                    xor_acc ^= b;
                    pos = int'(data_pos);
                    if (pos < TEXT_BYTES && pos % 3 != 2)
                    begin
                        text_bytes[(pos / 3) * 2 + pos % 3] = b;
                    end
                    if (pos + 1 >= int'(frame_len))
                    begin
                        parse_st = AWAIT_SUM;
                    end
                    if (pos < 127)
                    begin
                        data_pos++;
                    end
                end
            end
            AWAIT_SUM:
            begin
                res.ok = 1'b0;
                if (xor_acc == b && tag_ok())
                begin
                    for (int f = 0; f < tdfp_pkg::DATE_FIELDS; f++)
                    begin
                        if (3 * f < int'(frame_len))
                        begin
                            date_now[f] = digits_value(text_bytes[2 * f], text_bytes[2 * f + 1]);
                        end
                    end
                    res.ok = 1'b1;
                end
                res.day    = date_now[0];
                res.month  = date_now[1];
                res.year   = date_now[2];
                res.hour   = date_now[3];
                res.minute = date_now[4];
                res.second = date_now[5];
                pending_dates.push_back(res);
                parse_st = AWAIT_START;
            end
            default:
            begin
                parse_st = AWAIT_START;
            end
        endcase
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && burst_left == 0)
        begin
            repeat ($urandom_range(0, 6)) idle_cycle();
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        if (parse_st != AWAIT_START || b == tdfp_pkg::START_BYTE)
        begin
            items_sent++;
        end
        absorb_byte(b);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == tdfp_pkg::CFG_TAG_VALUE)
        begin
            tag_value_cfg = val;
        end
        else
        begin
            tag_length_cfg = val[2:0];
        end
    endtask

    task automatic drain_results(input int extra);
        while (pending_dates.size() != 0)
        begin
            idle_cycle();
        end
        repeat (extra) idle_cycle();
    endtask

    task automatic send_frame();
        logic [7:0] frame_q [$];
        logic [7:0] b;
        logic [7:0] last;
        logic [7:0] sum;
        int         r;
        int         n_cfg;
        int         n_tag;
        int         len;
        int         count;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            frame_q.push_back(8'($urandom_range(0, 254)));
        end
        else if (r < 9)
        begin
            b = 8'($urandom);
            if (b[4:0] == tdfp_pkg::TAG_FIRST_MASK)
            begin
                b[0] = 1'b0;
            end
            frame_q.push_back(tdfp_pkg::START_BYTE);
            frame_q.push_back(b);
        end
        else
        begin
            frame_q.push_back(tdfp_pkg::START_BYTE);
            n_cfg = (tag_length_cfg > 4) ? 4 : int'(tag_length_cfg);
            if (n_cfg == 0)
            begin
                last = 8'($urandom) | {3'b000, tdfp_pkg::TAG_FIRST_MASK};
                frame_q.push_back(last);
            end
            else
            begin
                for (int k = 0; k < n_cfg; k++)
                begin
                    frame_q.push_back(tag_value_cfg[31 - 8 * k -: 8]);
                end
                last = tag_value_cfg[31 - 8 * (n_cfg - 1) -: 8];
            end
            n_tag = frame_q.size() - 1;
            while (last[7] || n_tag < 2)
            begin
                last = 8'($urandom);
                if (n_tag >= 6)
                begin
                    last[7] = 1'b0;
                end
                frame_q.push_back(last);
                n_tag++;
            end
            if ($urandom_range(0, 99) < 8)
            begin
                frame_q[$urandom_range(1, n_tag)] ^= 8'(1 << $urandom_range(0, 7));
            end
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                frame_q.push_back(8'h80 | 8'($urandom));
            end
            else
            begin
                if (r < 60)
                begin
                    len = TEXT_BYTES;
                end
                else if (r < 80)
                begin
                    len = $urandom_range(0, TEXT_BYTES - 1);
                end
                else if (r < 96)
                begin
                    len = $urandom_range(TEXT_BYTES + 1, 30);
                end
                else
                begin
                    len = $urandom_range(31, 127);
                end
                frame_q.push_back(8'(len));
                count = (len == 0) ? 1 : len;
                for (int pos = 0; pos < count; pos++)
                begin
                    if (pos >= TEXT_BYTES || $urandom_range(0, 99) < 6)
                    begin
                        b = 8'($urandom);
                    end
                    else if (pos % 3 != 2)
                    begin
                        b = tdfp_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
                    end
                    else if (pos == 8)
                    begin
                        b = 8'h20;
                    end
                    else if (pos < 8)
                    begin
                        b = 8'h2E;
                    end
                    else
                    begin
                        b = 8'h3A;
                    end
                    frame_q.push_back(b);
                end
                sum = '0;
                foreach (frame_q[i]) sum ^= frame_q[i];
                if ($urandom_range(0, 99) < 10)
                begin
                    sum ^= 8'($urandom_range(1, 255));
                end
                frame_q.push_back(sum);
            end
        end
        foreach (frame_q[i]) send_byte(frame_q[i]);
    endtask

    task automatic compare_field(input string label, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        stamp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_dates.size() == 0)
            begin
                $display("%0t ns: result with none expected, checksum_ok %0d day %0d",
                         $time, checksum_ok, day);
                mismatches++;
            end
            else
            begin
                want = pending_dates.pop_front();
                compare_field("checksum_ok", want.ok, checksum_ok);
                compare_field("day", want.day, day);
                compare_field("month", want.month, month);
                compare_field("year", want.year, year);
                compare_field("hour", want.hour, hour);
                compare_field("minute", want.minute, minute);
                compare_field("second", want.second, second);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tlv_datetime_frame_parser regression: fail");
            $finish;
        end
    end

    initial
    begin : result_side
        int          hold_left;
        int          mode_left;
        bit          held_once;
        stall_mode_t ready_mode;
        hold_left  = 0;
        mode_left  = 0;
        held_once  = 1'b0;
        ready_mode = ALWAYS_READY;
        forever
        begin
            @(negedge clk);
            if (!held_once && results_seen >= 8)
            begin
                held_once = 1'b1;
                hold_left = 400;
            end
            if (mode_left == 0)
            begin
                ready_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    ALWAYS_READY: out_ready <= 1'b1;
                    HALF_READY:   out_ready <= 1'($urandom_range(0, 1));
                    SELDOM_READY: out_ready <= ($urandom_range(0, 3) == 0);
                    default:      out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        vector_t     row;
        logic [7:0]  b;
        logic [2:0]  tag_len;
        logic [31:0] tag_val;
        int          goal;
        bit          paused;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = tdfp_pkg::CFG_TAG_VALUE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        rx_byte        = '0;
        out_ready      = 1'b0;
        tag_value_cfg  = '0;
        tag_length_cfg = 3'd1;
        parse_st       = AWAIT_START;
        xor_acc        = '0;
        frame_len      = '0;
        data_pos       = '0;
        tag_pos        = '0;
        foreach (tag_seen[k]) tag_seen[k] = '0;
        foreach (text_bytes[k]) text_bytes[k] = '0;
        foreach (date_now[k]) date_now[k] = '0;
        items_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        stuck_cycles   = 0;
        burst_left     = 0;
        gaps_on        = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(tdfp_pkg::CFG_TAG_VALUE, 32'h3F00_0000);
        write_reg(tdfp_pkg::CFG_TAG_LENGTH, 32'd1);
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            row = DIRECTED[i];
            case (row.kind)
                ROW_SUM:     b = xor_acc;
                ROW_BAD_SUM: b = xor_acc ^ 8'h5A;
                default:     b = row.value;
            endcase
            send_byte(b);
            if (row.typed)
            begin
                pending_dates[pending_dates.size() - 1] = row.want;
            end
        end
        drain_results(SETTLE);

        for (int p = 0; p < PHASES; p++)
        begin
            tag_len = PHASE_LENGTH[p];
            if (tag_len == 3'd7)
            begin
                tag_val = '1;
            end
            else if (tag_len == 3'd0)
            begin
                tag_val = '0;
            end
            else
            begin
                tag_val = make_tag(int'(tag_len));
            end
            write_reg(tdfp_pkg::CFG_TAG_VALUE, tag_val);
            write_reg(tdfp_pkg::CFG_TAG_LENGTH, 32'(tag_len));
            gaps_on = (p != 3);
            goal    = items_sent + RANDOM_ITEMS / PHASES;
            paused  = 1'b0;
            while (items_sent < goal)
            begin
                if (p == 2 && !paused && items_sent >= goal - RANDOM_ITEMS / (2 * PHASES))
                begin
                    paused = 1'b1;
                    drain_results(0);
                end
                send_frame();
            end
            // flush any partial frame so the parser is idle before the next write
            while (parse_st != AWAIT_START)
            begin
                send_byte(8'h00);
            end
            drain_results(SETTLE);
        end

        drain_results(TAIL_CYCLES);
        if (mismatches == 0)
        begin
            $display("tlv_datetime_frame_parser regression: pass");
        end
        else
        begin
            $display("tlv_datetime_frame_parser regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tdfp_pkg.sv
sv/tdfp_queue.sv
sv/tdfp_front.sv
sv/tdfp_back.sv
sv/tlv_datetime_frame_parser.sv
verif/tlv_datetime_frame_parser_test.sv
